/* rtl/core/isu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_pkg
// Shared constants and types for the insertion sorter cell chain.
// ----------------------------------------------------------------------------
package isu_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the broadcast key
        logic shift;  // move contents one place toward cell 0
    } t_cell_ctrl;

endpackage

/* rtl/core/isu_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_cell
// One slot of the sorted chain: holds a value and its valid bit.
// ----------------------------------------------------------------------------
module isu_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isu_pkg::t_cell_ctrl i_ctrl,
    input  isu_pkg::t_data      i_key,
    input  isu_pkg::t_data      i_left_val,
    input  logic                i_left_vld,
    input  logic                i_left_gt,
    input  isu_pkg::t_data      i_right_val,
    input  logic                i_right_vld,
    output isu_pkg::t_data      o_val,
    output logic                o_vld,
    output logic                o_gt
);
    import isu_pkg::*;

    t_data r_val;
    logic  r_vld;
    t_data n_val;
    logic  n_vld;

    // empty slots count as greater so the key lands in the first free one
    assign o_gt  = !r_vld || (r_val > i_key);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctrl.shift) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_ctrl.ins && o_gt) begin
            // strictly greater moves up: equal values keep arrival order
            n_val = i_left_gt ? i_left_val : i_key;
            n_vld = r_vld || i_left_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

/* rtl/core/insertion_sorter_unit.sv */
`timescale 1ns / 1ps
// Latency: an item that finds room is inserted in the cycle it is accepted; after
//   the last item of a batch the smallest result is offered in the next cycle.
// Throughput: one item per cycle while filling, one result per cycle while
//   draining and i_ready is high; input is held off while the chain drains.
// Reset: clears the valid bits, the drain flag and the overflow flag; data undefined.
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Stable ascending batch sorter built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
module insertion_sorter_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input item channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  isu_pkg::t_data         i_value,
    input  logic                   i_last,
    // result item channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output isu_pkg::t_data         o_value_res,
    output logic                   o_last_res,
    output logic                   o_overflow
);
    import isu_pkg::*;

    // chain state seen from the top
    t_data               w_val [CAPACITY];
    logic [CAPACITY-1:0] w_vld;
    logic [CAPACITY-1:0] w_gt;
    t_cell_ctrl          w_ctrl;

    logic r_emit;     // chain is draining a finished batch
    logic r_dropped;  // an item of this batch found the chain full
    logic n_emit;
    logic n_dropped;

    logic w_in_acc;
    logic w_out_acc;
    logic w_full;

    // last cell occupied means no room for another item
    assign w_full    = w_vld[CAPACITY-1];
    assign o_ready   = !r_emit;
    assign w_in_acc  = i_valid && o_ready;
    assign o_valid   = r_emit;
    assign w_out_acc = o_valid && i_ready;

    // insertion broadcasts the key to every cell; draining shifts toward cell 0
    assign w_ctrl.ins   = w_in_acc && !w_full;
    assign w_ctrl.shift = w_out_acc;

    // cell 0 is the head of the sorted order
    assign o_value_res = w_val[0];
    assign o_last_res  = !w_vld[1];
    assign o_overflow  = r_dropped;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data w_left_val;
        logic  w_left_vld;
        logic  w_left_gt;
        t_data w_right_val;
        logic  w_right_vld;

        if (g == 0) begin : g_head
            // key always goes into cell 0 if it is the first greater slot
            assign w_left_val = '0;
            assign w_left_vld = 1'b1;
            assign w_left_gt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[g-1];
            assign w_left_vld = w_vld[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_val = '0;
            assign w_right_vld = 1'b0;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
            assign w_right_vld = w_vld[g+1];
        end

        isu_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_key       (i_value),
            .i_left_val  (w_left_val),
            .i_left_vld  (w_left_vld),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .i_right_vld (w_right_vld),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g]),
            .o_gt        (w_gt[g])
        );
    end

    always_comb begin
        n_emit    = r_emit;
        n_dropped = r_dropped;
        if (w_in_acc) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end
            if (i_last) begin
                n_emit = 1'b1;
            end
        end
        if (w_out_acc && o_last_res) begin
            // batch fully delivered: chain is empty again
            n_emit    = 1'b0;
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit    <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_emit    <= n_emit;
            r_dropped <= n_dropped;
        end
    end

    // adjacent occupied cells must be in ascending order
    logic [CAPACITY-2:0] w_order_ok;
    for (genvar g = 0; g < CAPACITY - 1; g++) begin : g_chk
        assign w_order_ok[g] = !w_vld[g+1] || (w_val[g] <= w_val[g+1]);
    end

    // occupied cells form an unbroken run starting at cell 0
    a_vld_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld & (w_vld + CAPACITY'(1))) == '0)
        else $error("isu: gap in occupied cells");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order_ok)
        else $error("isu: chain out of order");

    a_emit_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> w_vld[0])
        else $error("isu: draining an empty chain");

    a_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_res) |=> (!o_valid && w_vld == '0 && !r_dropped))
        else $error("isu: chain not empty after final result");

    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last) |=> o_valid)
        else $error("isu: last item did not start draining");

endmodule
